FILE: hw/rtl/bpsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsa_pkg
// Shared types and codes of the box projected screen area block.
// ----------------------------------------------------------------------------
package bpsa_pkg;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_AREA = 1'b1;

	localparam logic [1:0] PICK_MODEL = 2'd0;
	localparam logic [1:0] PICK_VIEW  = 2'd1;
	localparam logic [1:0] PICK_PROJ  = 2'd2;

	localparam int MAT_COUNT    = 3;
	localparam int MAT_SIZE     = 16;
	localparam int OUT_FRAC     = 16;
	localparam int AREA_W       = 17;
	localparam int CORNER_COUNT = 8;

	// position of a corner inside its item
	typedef struct packed {
		logic first;
		logic last;
	} tag_t;

endpackage

FILE: hw/rtl/bpsa_mat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsa_mat
// One 4x4 matrix times vector stage: products, then floored row sums with
// saturation to 32 bits. Two register stages.
// ----------------------------------------------------------------------------
module bpsa_mat #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  bpsa_pkg::tag_t     in_tag,
	input  logic signed [31:0] in_vec [4],
	input  logic signed [31:0] mat [16],
	output logic               out_vld,
	output bpsa_pkg::tag_t     out_tag,
	output logic signed [31:0] out_vec [4],
	output logic               active
);

	localparam logic signed [65:0] SMAX = 66'sd2147483647;
	localparam logic signed [65:0] SMIN = -66'sd2147483648;

	logic               vld_s1, vld_s2;
	bpsa_pkg::tag_t     tag_s1, tag_s2;
	logic signed [63:0] prod_s1 [16];
	logic signed [31:0] row_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		tag_s2 <= tag_s1;
	end

	for (genvar i = 0; i < 16; i++) begin : g_prod
		always_ff @(posedge clk) begin
			prod_s1[i] <= $signed(mat[i]) * $signed(in_vec[i % 4]);
		end
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		logic signed [65:0] sum;
		always_comb begin
			sum = 66'(prod_s1[r*4]   >>> FRAC_BITS) + 66'(prod_s1[r*4+1] >>> FRAC_BITS)
			    + 66'(prod_s1[r*4+2] >>> FRAC_BITS) + 66'(prod_s1[r*4+3] >>> FRAC_BITS);
		end
		always_ff @(posedge clk) begin
			if (sum > SMAX)
				row_s2[r] <= 32'sh7fffffff;
			else if (sum < SMIN)
				row_s2[r] <= 32'sh80000000;
			else
				row_s2[r] <= sum[31:0];
		end
		assign out_vec[r] = row_s2[r];
	end

	assign out_vld = vld_s2;
	assign out_tag = tag_s2;
	assign active  = vld_s1 | vld_s2;

endmodule

FILE: hw/rtl/bpsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsa_div
// Pipelined signed divide (p * 2^FRAC_BITS) / w, truncated toward zero and
// saturated to 32 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module bpsa_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  bpsa_pkg::tag_t     in_tag,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               out_vld,
	output bpsa_pkg::tag_t     out_tag,
	output logic signed [31:0] quot
);

	localparam int NW = 32 + FRAC_BITS;
	localparam logic [NW-1:0] POS_LIM = {{(NW-32){1'b0}}, 32'h7fffffff};
	localparam logic [NW-1:0] NEG_LIM = {{(NW-32){1'b0}}, 32'h80000000};

	logic               v_s   [NW+1];
	bpsa_pkg::tag_t     tag_s [NW+1];
	logic [NW-1:0]      n_s   [NW+1];
	logic [31:0]        d_s   [NW+1];
	logic [31:0]        r_s   [NW+1];
	logic [NW-1:0]      q_s   [NW+1];
	logic               neg_s [NW+1];
	logic               nz_s  [NW+1];
	logic               vld_o;
	bpsa_pkg::tag_t     tag_o;
	logic signed [31:0] q_o;
	logic [31:0]        num_mag, den_mag;

	assign num_mag = num[31] ? (~num + 32'd1) : num;
	assign den_mag = den[31] ? (~den + 32'd1) : den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		n_s[0]   <= {num_mag, {FRAC_BITS{1'b0}}};
		d_s[0]   <= den_mag;
		r_s[0]   <= '0;
		q_s[0]   <= '0;
		neg_s[0] <= num[31] ^ den[31];
		nz_s[0]  <= (num == 32'sd0);
	end

	for (genvar i = 0; i < NW; i++) begin : g_step
		localparam int B = NW - 1 - i;
		logic [32:0] sh;
		logic [33:0] df;
		logic        ge;
		always_comb begin
			sh = {r_s[i], n_s[i][B]};
			df = {1'b0, sh} - {2'b00, d_s[i]};
			ge = !df[33];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			tag_s[i+1]   <= tag_s[i];
			n_s[i+1]     <= n_s[i];
			d_s[i+1]     <= d_s[i];
			neg_s[i+1]   <= neg_s[i];
			nz_s[i+1]    <= nz_s[i];
			r_s[i+1]     <= ge ? df[31:0] : sh[31:0];
			q_s[i+1]     <= q_s[i] | ({{(NW-1){1'b0}}, ge} << B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else
			vld_o <= v_s[NW];
	end

	always_ff @(posedge clk) begin
		tag_o <= tag_s[NW];
		if (nz_s[NW])
			q_o <= 32'sd0;
		else if (!neg_s[NW])
			q_o <= (q_s[NW] > POS_LIM) ? 32'sh7fffffff : q_s[NW][31:0];
		else
			q_o <= (q_s[NW] > NEG_LIM) ? 32'sh80000000 : (~q_s[NW][31:0] + 32'd1);
	end

	assign out_vld = vld_o;
	assign out_tag = tag_o;
	assign quot    = q_o;

endmodule

FILE: hw/rtl/bpsa_rect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsa_rect
// Screen rectangle: min/max over the corners of an item, clamp to the view
// square, area multiply and scale.
// ----------------------------------------------------------------------------
module bpsa_rect #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	input  bpsa_pkg::tag_t                  in_tag,
	input  logic signed [31:0]              sx,
	input  logic signed [31:0]              sy,
	output logic                            done,
	output logic [bpsa_pkg::AREA_W-1:0]     area,
	output logic                            off
);

	localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] NEG_ONE = -ONE;
	localparam int WW = FRAC_BITS + 2;
	localparam int SH = 2 * FRAC_BITS + 2 - bpsa_pkg::OUT_FRAC;

	logic signed [31:0] minx_q, maxx_q, miny_q, maxy_q;
	logic signed [31:0] nminx, nmaxx, nminy, nmaxy;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [31:0] minx_s1, maxx_s1, miny_s1, maxy_s1;
	logic signed [31:0] cminx, cmaxx, cminy, cmaxy;
	logic signed [32:0] dx, dy;
	logic [WW-1:0]      wx_s2, wy_s2;
	logic               off_s2, off_s3, off_s4;
	logic [2*WW-1:0]    prod_s3;
	logic [bpsa_pkg::AREA_W-1:0] area_s4;
	logic               off_now;

	always_comb begin
		if (in_tag.first) begin
			nminx = sx;
			nmaxx = sx;
			nminy = sy;
			nmaxy = sy;
		end else begin
			nminx = (sx < minx_q) ? sx : minx_q;
			nmaxx = (sx > maxx_q) ? sx : maxx_q;
			nminy = (sy < miny_q) ? sy : miny_q;
			nmaxy = (sy > maxy_q) ? sy : maxy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			minx_q <= nminx;
			maxx_q <= nmaxx;
			miny_q <= nminy;
			maxy_q <= nmaxy;
		end
		minx_s1 <= nminx;
		maxx_s1 <= nmaxx;
		miny_s1 <= nminy;
		maxy_s1 <= nmaxy;
	end

	always_comb begin
		off_now = (maxx_s1 < NEG_ONE) || (maxy_s1 < NEG_ONE) ||
		          (minx_s1 > ONE) || (miny_s1 > ONE);
		cmaxx = (maxx_s1 > ONE) ? ONE : maxx_s1;
		cmaxy = (maxy_s1 > ONE) ? ONE : maxy_s1;
		cminx = (minx_s1 < NEG_ONE) ? NEG_ONE : minx_s1;
		cminy = (miny_s1 < NEG_ONE) ? NEG_ONE : miny_s1;
		dx    = 33'(cmaxx) - 33'(cminx);
		dy    = 33'(cmaxy) - 33'(cminy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld & in_tag.last;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		off_s2  <= off_now;
		wx_s2   <= dx[WW-1:0];
		wy_s2   <= dy[WW-1:0];
		off_s3  <= off_s2;
		prod_s3 <= wx_s2 * wy_s2;
		off_s4  <= off_s3;
		area_s4 <= off_s3 ? '0 : prod_s3[SH +: bpsa_pkg::AREA_W];
	end

	assign done = vld_s4;
	assign area = area_s4;
	assign off  = off_s4;

endmodule

FILE: hw/rtl/box_projected_screen_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_projected_screen_area
// Projected screen area of an axis-aligned box under model, view and
// projection matrices, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A load item (func 0) writes one matrix entry and gives no result; it is
// held off by busy while corners of earlier compute items are still being
// issued or in the matrix stages. A compute item (func 1) issues its eight
// corners one per cycle, and the next compute item can be taken as the last
// corner issues; all corners share the single corner path (three matrix
// stages of 16 multipliers each, then two pipelined dividers). The result
// appears on done, screen_area and off_screen for one cycle. The receiver
// cannot stall; results come out in item order. Matrix entries read before
// they are written give undefined results.
// ----------------------------------------------------------------------------
module box_projected_screen_area #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [1:0]                  matrix_pick,
	input  logic [3:0]                  entry_index,
	input  logic signed [31:0]          entry_value,
	input  logic signed [31:0]          box_min_x,
	input  logic signed [31:0]          box_min_y,
	input  logic signed [31:0]          box_min_z,
	input  logic signed [31:0]          box_max_x,
	input  logic signed [31:0]          box_max_y,
	input  logic signed [31:0]          box_max_z,
	output logic                        done,
	output logic [bpsa_pkg::AREA_W-1:0] screen_area,
	output logic                        off_screen
);

	localparam int CNT_W = $clog2(bpsa_pkg::CORNER_COUNT);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(bpsa_pkg::CORNER_COUNT - 1);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	logic               accept;
	logic               mat_busy;
	logic signed [31:0] mat_q [bpsa_pkg::MAT_COUNT][bpsa_pkg::MAT_SIZE];
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];
	logic               issue_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               vld_s1;
	bpsa_pkg::tag_t     tag_s1;
	logic signed [31:0] c_s1 [4];

	logic               v_a, v_b, v_p, act_a, act_b, act_p;
	bpsa_pkg::tag_t     t_a, t_b, t_p, t_dx, t_dy;
	logic signed [31:0] a_vec [4];
	logic signed [31:0] b_vec [4];
	logic signed [31:0] p_vec [4];
	logic               v_dx, v_dy;
	logic signed [31:0] sx, sy;

	// Hold loads back while any corner still reads the matrices.
	assign mat_busy = issue_q | vld_s1 | act_a | act_b | act_p;
	assign busy     = (issue_q && (cnt_q != LAST)) ||
	                  ((func == bpsa_pkg::FUNC_LOAD) && mat_busy);
	assign accept   = start && !busy;

	// Matrix store: written at one entry, each entry read by its own multiplier.
	always_ff @(posedge clk) begin
		if (accept && (func == bpsa_pkg::FUNC_LOAD) &&
		    ((matrix_pick == bpsa_pkg::PICK_MODEL) ||
		     (matrix_pick == bpsa_pkg::PICK_VIEW) ||
		     (matrix_pick == bpsa_pkg::PICK_PROJ)))
			mat_q[matrix_pick][entry_index] <= entry_value;
	end

	// Latch the box of a compute item; corners issue from it.
	always_ff @(posedge clk) begin
		if (accept && (func == bpsa_pkg::FUNC_AREA)) begin
			bmin_q[0] <= box_min_x;
			bmin_q[1] <= box_min_y;
			bmin_q[2] <= box_min_z;
			bmax_q[0] <= box_max_x;
			bmax_q[1] <= box_max_y;
			bmax_q[2] <= box_max_z;
		end
	end

	// Advance the corner counter; a new item may start on the last corner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			if (accept && (func == bpsa_pkg::FUNC_AREA)) begin
				issue_q <= 1'b1;
				cnt_q   <= '0;
			end else if (issue_q) begin
				if (cnt_q == LAST)
					issue_q <= 1'b0;
				else
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Corner k picks max along x, y, z by bits 0, 1, 2 of k.
	always_ff @(posedge clk) begin
		tag_s1.first <= (cnt_q == '0);
		tag_s1.last  <= (cnt_q == LAST);
		c_s1[0] <= cnt_q[0] ? bmax_q[0] : bmin_q[0];
		c_s1[1] <= cnt_q[1] ? bmax_q[1] : bmin_q[1];
		c_s1[2] <= cnt_q[2] ? bmax_q[2] : bmin_q[2];
		c_s1[3] <= ONE;
	end

	bpsa_mat #(.FRAC_BITS(FRAC_BITS)) u_model (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .in_tag(tag_s1), .in_vec(c_s1),
		.mat(mat_q[0]), .out_vld(v_a), .out_tag(t_a), .out_vec(a_vec), .active(act_a)
	);

	bpsa_mat #(.FRAC_BITS(FRAC_BITS)) u_view (
		.clk(clk), .arst_n(arst_n), .in_vld(v_a), .in_tag(t_a), .in_vec(a_vec),
		.mat(mat_q[1]), .out_vld(v_b), .out_tag(t_b), .out_vec(b_vec), .active(act_b)
	);

	bpsa_mat #(.FRAC_BITS(FRAC_BITS)) u_proj (
		.clk(clk), .arst_n(arst_n), .in_vld(v_b), .in_tag(t_b), .in_vec(b_vec),
		.mat(mat_q[2]), .out_vld(v_p), .out_tag(t_p), .out_vec(p_vec), .active(act_p)
	);

	// Perspective divide of x and y by w, side by side.
	bpsa_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .in_vld(v_p), .in_tag(t_p),
		.num(p_vec[0]), .den(p_vec[3]), .out_vld(v_dx), .out_tag(t_dx), .quot(sx)
	);

	bpsa_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .in_vld(v_p), .in_tag(t_p),
		.num(p_vec[1]), .den(p_vec[3]), .out_vld(v_dy), .out_tag(t_dy), .quot(sy)
	);

	bpsa_rect #(.FRAC_BITS(FRAC_BITS)) u_rect (
		.clk(clk), .arst_n(arst_n), .in_vld(v_dx), .in_tag(t_dx),
		.sx(sx), .sy(sy), .done(done), .area(screen_area), .off(off_screen)
	);

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == bpsa_pkg::FUNC_LOAD)) |-> !mat_busy)
		else $error("matrix load taken while corners in flight");

	a_issue_run: assert property (@(posedge clk) disable iff (!arst_n)
		(issue_q && (cnt_q != LAST)) |=> (issue_q && (cnt_q == $past(cnt_q) + CNT_W'(1))))
		else $error("corner issue broke off early");

	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dx == v_dy) && (!v_dx || (t_dx == t_dy)))
		else $error("x and y dividers out of step");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && off_screen) |-> (screen_area == '0))
		else $error("off-screen result with nonzero area");

	a_area_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (screen_area <= bpsa_pkg::AREA_W'(65536)))
		else $error("area above one");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for box_projected_screen_area. Loads the model, view
// and projection matrices through load items, sends compute items and checks
// each strobed result against an in-bench fixed-point prediction of the
// projected screen rectangle area and the off-screen flag.
// ----------------------------------------------------------------------------
module tb;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam int TAIL_CYCLES = 120;
	localparam logic [1:0] PICK_UNUSED = 2'd3;

	typedef longint vec4_t[4];

	typedef struct {
		logic [bpsa_pkg::AREA_W-1:0] area;
		logic                        off;
	} area_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic func;
	logic [1:0] matrix_pick;
	logic [3:0] entry_index;
	logic signed [31:0] entry_value;
	logic signed [31:0] box_min_x, box_min_y, box_min_z;
	logic signed [31:0] box_max_x, box_max_y, box_max_z;
	logic done;
	logic [bpsa_pkg::AREA_W-1:0] screen_area;
	logic off_screen;

	// predictor copy of the three matrices, index = pick*16 + entry
	longint matrices[bpsa_pkg::MAT_COUNT*bpsa_pkg::MAT_SIZE];
	area_result_t pending_areas[$];
	int mismatch_count;
	int idle_pct;

	box_projected_screen_area u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.matrix_pick(matrix_pick), .entry_index(entry_index),
		.entry_value(entry_value),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.done(done), .screen_area(screen_area), .off_screen(off_screen)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// one matrix stage: exact products, floored shift, saturated row sum
	function automatic vec4_t transform(int base, vec4_t v);
		vec4_t r;
		longint acc;
		for (int row = 0; row < 4; row++) begin
			acc = 0;
			for (int col = 0; col < 4; col++)
				acc += (matrices[base + row*4 + col] * v[col]) >>> FRAC;
			r[row] = clip32(acc);
		end
		return r;
	endfunction

	// perspective divide, saturating on zero w
	function automatic longint w_divide(longint num, longint w);
		if (w == 0) begin
			if (num > 0) return 64'sd2147483647;
			if (num < 0) return -64'sd2147483648;
			return 0;
		end
		return clip32((num * ONE) / w);
	endfunction

	function automatic area_result_t predict_area(longint lo[3], longint hi[3]);
		area_result_t res;
		vec4_t c, p;
		longint sx, sy, min_x, min_y, max_x, max_y, wx, wy;
		for (int k = 0; k < bpsa_pkg::CORNER_COUNT; k++) begin
			c[0] = k[0] ? hi[0] : lo[0];
			c[1] = k[1] ? hi[1] : lo[1];
			c[2] = k[2] ? hi[2] : lo[2];
			c[3] = ONE;
			p = transform(2*bpsa_pkg::MAT_SIZE,
				transform(bpsa_pkg::MAT_SIZE, transform(0, c)));
			sx = w_divide(p[0], p[3]);
			sy = w_divide(p[1], p[3]);
			if (k == 0 || sx < min_x) min_x = sx;
			if (k == 0 || sx > max_x) max_x = sx;
			if (k == 0 || sy < min_y) min_y = sy;
			if (k == 0 || sy > max_y) max_y = sy;
		end
		if (max_x < -ONE || max_y < -ONE || min_x > ONE || min_y > ONE) begin
			res.area = '0;
			res.off = 1'b1;
			return res;
		end
		if (max_x > ONE) max_x = ONE;
		if (max_y > ONE) max_y = ONE;
		if (min_x < -ONE) min_x = -ONE;
		if (min_y < -ONE) min_y = -ONE;
		wx = max_x - min_x;
		wy = max_y - min_y;
		res.area = bpsa_pkg::AREA_W'((wx * wy) >> (2*FRAC + 2 - bpsa_pkg::OUT_FRAC));
		res.off = 1'b0;
		return res;
	endfunction

	// ---------------------------------------------------------------- driving
	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// drive one item at the falling edge, hold it until taken, then predict
	task automatic send_item(logic f, logic [1:0] pick, logic [3:0] idx,
			logic signed [31:0] val, logic signed [31:0] bx[6]);
		longint lo[3], hi[3];
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		func = f;
		matrix_pick = pick;
		entry_index = idx;
		entry_value = val;
		{box_min_x, box_min_y, box_min_z} = {bx[0], bx[1], bx[2]};
		{box_max_x, box_max_y, box_max_z} = {bx[3], bx[4], bx[5]};
		do @(posedge clk); while (busy);
		if (f == bpsa_pkg::FUNC_LOAD) begin
			if (pick != PICK_UNUSED) matrices[pick*bpsa_pkg::MAT_SIZE + idx] = val;
		end else begin
			for (int i = 0; i < 3; i++) begin
				lo[i] = bx[i];
				hi[i] = bx[i+3];
			end
			pending_areas.insert(pending_areas.size(), predict_area(lo, hi));
		end
	endtask

	task automatic load_entry(logic [1:0] pick, int idx, logic signed [31:0] val);
		logic signed [31:0] bx[6];
		foreach (bx[i]) bx[i] = $urandom;	// box ports are don't-care on a load
		send_item(bpsa_pkg::FUNC_LOAD, pick, idx[3:0], val, bx);
	endtask

	task automatic compute_box(logic signed [31:0] bx[6]);
		send_item(bpsa_pkg::FUNC_AREA, 2'($urandom), 4'($urandom), $urandom, bx);
	endtask

	// hold the sender until every expected result has arrived
	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (pending_areas.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [31:0] small_coord(int span);
		return $signed($urandom_range(2*span)) - span;
	endfunction

	// ---------------------------------------------------------------- checking
	always @(posedge clk) begin
		area_result_t want;
		if (arst_n && done) begin
			if (pending_areas.size() == 0) begin
				report_mismatch("result with no item outstanding", screen_area, 0);
			end else begin
				want = pending_areas.pop_front();
				if (screen_area !== want.area)
					report_mismatch("screen_area", screen_area, want.area);
				if (off_screen !== want.off)
					report_mismatch("off_screen", off_screen, want.off);
			end
		end
	end

	// ---------------------------------------------------------------- tests
	// identity model and view, simple perspective: w = -z
	task automatic test_matrix_load;
		for (int i = 0; i < bpsa_pkg::MAT_SIZE; i++) begin
			load_entry(bpsa_pkg::PICK_MODEL, i, (i % 5 == 0) ? 32'sh10000 : 32'sh0);
			load_entry(bpsa_pkg::PICK_VIEW, i, (i % 5 == 0) ? 32'sh10000 : 32'sh0);
			load_entry(bpsa_pkg::PICK_PROJ, i,
				(i == 0 || i == 5 || i == 10) ? 32'sh10000 :
				(i == 14) ? -32'sh10000 : 32'sh0);
		end
	endtask

	task automatic test_special_boxes;
		logic signed [31:0] bx[6];
		// box in front of the camera, fully on screen
		bx = '{-32'sh8000, -32'sh8000, -32'sh20000, 32'sh8000, 32'sh8000, -32'sh10000};
		compute_box(bx);
		// reversed box gives the same corner set
		bx = '{32'sh8000, 32'sh8000, -32'sh10000, -32'sh8000, -32'sh8000, -32'sh20000};
		compute_box(bx);
		// far off to the side
		bx = '{32'sh80000, 32'sh80000, -32'sh10000, 32'sh90000, 32'sh90000, -32'sh8000};
		compute_box(bx);
		// whole screen covered
		bx = '{-32'sh100000, -32'sh100000, -32'sh10000,
			32'sh100000, 32'sh100000, -32'sh8000};
		compute_box(bx);
		// field extremes, saturating the stages
		bx = '{32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		compute_box(bx);
		bx = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000, 32'h7fffffff, 32'h0};
		compute_box(bx);
		// a load into the unused matrix slot is dropped
		load_entry(PICK_UNUSED, 15, 32'h7fffffff);
		compute_box('{-32'sh8000, -32'sh8000, -32'sh18000,
			32'sh8000, 32'sh8000, -32'sh10000});
		// zero w: clear the projection w row so every divide of a nonzero value saturates
		drain();
		load_entry(bpsa_pkg::PICK_PROJ, 14, 32'sh0);
		compute_box('{-32'sh8000, -32'sh8000, -32'sh10000, 32'sh8000, 32'sh8000, 32'sh10000});
		compute_box('{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
		compute_box('{32'sh10000, -32'sh20000, 32'sh0, 32'sh20000, -32'sh10000, 32'sh0});
		load_entry(bpsa_pkg::PICK_PROJ, 14, -32'sh10000);
		// extreme entry values, then restore
		load_entry(bpsa_pkg::PICK_MODEL, 3, 32'h7fffffff);
		load_entry(bpsa_pkg::PICK_MODEL, 7, 32'h80000000);
		compute_box('{-32'sh8000, -32'sh8000, -32'sh18000,
			32'sh8000, 32'sh8000, -32'sh10000});
		load_entry(bpsa_pkg::PICK_MODEL, 3, 32'sh0);
		load_entry(bpsa_pkg::PICK_MODEL, 7, 32'sh0);
		drain();
	endtask

	// mostly plausible scenes with random content, some raw noise
	task automatic test_random_scenes(int pct, int count);
		logic signed [31:0] bx[6];
		logic signed [31:0] val;
		int idx;
		int sel;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			if (sel < 18) begin
				idx = $urandom_range(15);
				// near-identity entries keep most boxes on screen
				if ($urandom_range(9) == 0)
					val = $urandom;
				else if (idx % 5 == 0)
					val = 32'sh10000 + small_coord(32'h8000);
				else
					val = small_coord(32'h8000);
				if ($urandom_range(19) == 0)
					load_entry(PICK_UNUSED, idx, val);
				else if ($urandom_range(2) == 2 && idx == 14)
					load_entry(bpsa_pkg::PICK_PROJ, idx,
						-32'sh10000 + small_coord(32'h4000));
				else
					load_entry(2'($urandom_range(2)), idx, val);
			end else if (sel < 28) begin
				foreach (bx[i]) bx[i] = $urandom;
				compute_box(bx);
			end else begin
				foreach (bx[i]) bx[i] = small_coord(32'h40000);
				// keep z in front of the camera most of the time
				if ($urandom_range(3) != 0) begin
					bx[2] = -$signed($urandom_range(32'h80000, 32'h8000));
					bx[5] = -$signed($urandom_range(32'h80000, 32'h8000));
				end
				compute_box(bx);
			end
			if (n == count/2) drain();
		end
		drain();
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = bpsa_pkg::FUNC_LOAD;
		matrix_pick = bpsa_pkg::PICK_MODEL;
		entry_index = '0;
		entry_value = '0;
		{box_min_x, box_min_y, box_min_z} = '0;
		{box_max_x, box_max_y, box_max_z} = '0;
		mismatch_count = 0;
		idle_pct = 0;
		foreach (matrices[i]) matrices[i] = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_matrix_load();
		test_special_boxes();
		test_random_scenes(32, 650);
		test_random_scenes(83, 650);
		test_random_scenes(0, 700);
		if (mismatch_count == 0 && pending_areas.size() == 0)
			$display("[box_projected_screen_area] OK");
		else
			$display("[box_projected_screen_area] ERROR");
		$finish;
	end

	// run limit well above the slowest correct run
	initial begin
		#4ms;
		$display("[box_projected_screen_area] ERROR");
		$finish;
	end

endmodule

FILE: box_projected_screen_area.f
hw/rtl/bpsa_pkg.sv
hw/rtl/bpsa_mat.sv
hw/rtl/bpsa_div.sv
hw/rtl/bpsa_rect.sv
hw/rtl/box_projected_screen_area.sv
dv/tb.sv
